// ----- rtl/signed_decimal_field_formatter_assert.svh -----
// Assertion macros shared by the formatter RTL.
// Each macro compiles to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, but not while reset is held.
`define SDFF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, including those under reset.
`define SDFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SDFF_ASSERT(lbl, clk, rstn, prop, msg)
`define SDFF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/sdff_pkg.sv -----
package sdff_pkg;

    // Default saturation limit for width and precision.
    localparam int MAX_FIELD_DEF = 48;

    // Widths of the packed input fields.
    localparam int VALUE_W = 32;
    localparam int OPT_W   = 6;

    // A 32-bit magnitude has at most ten decimal digits.
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int DIGIT_W    = 4;
    localparam int CH_W       = 7;

    // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // ASCII codes.
    localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CH_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CH_W-1:0] CH_SPACE = 7'h20;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_BOUND,
        ST_EMIT
    } fmt_state_t;

endpackage

// ----- rtl/sdff_div10.sv -----
// Divides a 32-bit magnitude by ten with one reciprocal multiply.
// The remainder is rebuilt with shifts, one add and one subtract.
module sdff_div10
    import sdff_pkg::*;
(
    input  logic [VALUE_W-1:0] mag,
    output logic [VALUE_W-1:0] quot,
    output logic [DIGIT_W-1:0] rem
);

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   times_ten;
    logic [VALUE_W-1:0]   diff;

    // Quotient from the high part of the reciprocal product.
    always_comb begin
        prod = {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
        quot = VALUE_W'(prod >> RECIP_SHIFT);
    end

    // Remainder is mag - 10 * quot, always below ten.
    always_comb begin
        times_ten = (quot << 3) + (quot << 1);
        diff      = mag - times_ten;
        rem       = diff[DIGIT_W-1:0];
    end

endmodule

// ----- rtl/signed_decimal_field_formatter.sv -----
// Sequence: the conversion state extracts the decimal digits (zero to ten), the planning
// and boundary states lay out the field, then characters are emitted one per cycle while
// m_tready does not stall the output. A new item is accepted only in the idle state, once the
// previous one is done, since the divide-by-ten unit is shared and characters leave serially.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`include "signed_decimal_field_formatter_assert.svh"

module signed_decimal_field_formatter
    import sdff_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // value[31:0], field_width[37:32], has_precision[38], precision[44:39],
    // zero_pad[45], left_justify[46], unused[47]
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ch[6:0], zero fill[7]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // Counter width holds the longest field, MAX_FIELD + 1 characters.
    localparam int CNT_W = $clog2(MAX_FIELD + 2);

    fmt_state_t state_reg, state_next;

    logic [VALUE_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     w_reg;
    logic [CNT_W-1:0]     p_reg;
    logic                 hasp_reg;
    logic                 zp_reg;
    logic                 lj_reg;
    logic [DIG_IDX_W-1:0] ndig_reg;
    logic [DIGIT_W-1:0]   dig_reg [NUM_DIGITS];
    logic [CNT_W-1:0]     zeros_reg;
    logic [CNT_W-1:0]     pad_reg;
    logic [CNT_W-1:0]     a_reg, b_reg, c_reg, d_reg, n_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [DIG_IDX_W-1:0] dptr_reg;
    logic                 m_tvalid_reg;
    logic [CH_W-1:0]      m_ch_reg;
    logic                 m_last_reg;

    // Input field unpacking.
    logic [VALUE_W-1:0] in_value;
    logic [OPT_W-1:0]   in_width;
    logic               in_hasp;
    logic [OPT_W-1:0]   in_prec;
    logic               in_zp;
    logic               in_lj;
    logic               in_neg;
    logic [VALUE_W-1:0] in_mag;
    logic [OPT_W-1:0]   in_width_sat;
    logic [OPT_W-1:0]   in_prec_sat;
    logic               in_skip;

    assign in_value = s_tdata[31:0];
    assign in_width = s_tdata[37:32];
    assign in_hasp  = s_tdata[38];
    assign in_prec  = s_tdata[44:39];
    assign in_zp    = s_tdata[45];
    assign in_lj    = s_tdata[46];

    // Sign, magnitude, saturation and the empty-digit case at accept time.
    always_comb begin
        in_neg       = in_value[VALUE_W-1];
        in_mag       = in_neg ? (VALUE_W'(0) - in_value) : in_value;
        in_width_sat = (in_width > OPT_W'(MAX_FIELD)) ? OPT_W'(MAX_FIELD) : in_width;
        in_prec_sat  = (in_prec > OPT_W'(MAX_FIELD)) ? OPT_W'(MAX_FIELD) : in_prec;
        in_skip      = (in_mag == '0) && in_hasp && (in_prec == '0);
    end

    // Shared divide-by-ten unit.
    logic [VALUE_W-1:0] div_quot;
    logic [DIGIT_W-1:0] div_rem;

    sdff_div10 u_div10 (
        .mag  (mag_reg),
        .quot (div_quot),
        .rem  (div_rem)
    );

    // Field layout, computed in the planning state.
    logic [CNT_W-1:0] nd_ext;
    logic [CNT_W-1:0] p_eff;
    logic [CNT_W-1:0] zeros_calc;
    logic [CNT_W-1:0] body_calc;
    logic [CNT_W-1:0] pad_calc;
    logic [CNT_W-1:0] a_calc, b_calc, c_calc, d_calc, n_calc;

    always_comb begin
        nd_ext     = CNT_W'(ndig_reg);
        p_eff      = hasp_reg ? p_reg : '0;
        zeros_calc = (p_eff > nd_ext) ? (p_eff - nd_ext) : '0;
        body_calc  = CNT_W'(neg_reg) + zeros_calc + nd_ext;
        pad_calc   = (w_reg > body_calc) ? (w_reg - body_calc) : '0;
        if (zp_reg && !lj_reg && !hasp_reg) begin
            zeros_calc = zeros_calc + pad_calc;
            pad_calc   = '0;
        end
    end

    // Region boundaries: spaces, sign, zeros, digits, trailing spaces.
    always_comb begin
        a_calc = lj_reg ? '0 : pad_reg;
        b_calc = a_calc + CNT_W'(neg_reg);
        c_calc = b_calc + zeros_reg;
        d_calc = c_calc + CNT_W'(ndig_reg);
        n_calc = d_calc + (lj_reg ? pad_reg : '0);
    end

    // Control outputs of the sequencer.
    logic             emit_load;
    logic             emit_last;
    logic             emit_digit;
    logic [CH_W-1:0]  emit_ch;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        s_tready  = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_CONV:  s_tready  = 1'b0;
            ST_PLAN:  s_tready  = 1'b0;
            ST_BOUND: s_tready  = 1'b0;
            ST_EMIT:  emit_load = out_free;
            default:  s_tready  = 1'b0;
        endcase
    end

    // Character at the current position.
    always_comb begin
        emit_digit = 1'b0;
        emit_last  = ((idx_reg + CNT_W'(1)) == n_reg);
        priority if (idx_reg < a_reg) begin
            emit_ch = CH_SPACE;
        end else if (idx_reg < b_reg) begin
            emit_ch = CH_MINUS;
        end else if (idx_reg < c_reg) begin
            emit_ch = CH_ZERO;
        end else if (idx_reg < d_reg) begin
            emit_ch    = CH_ZERO + CH_W'(dig_reg[dptr_reg]);
            emit_digit = 1'b1;
        end else begin
            emit_ch = CH_SPACE;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_skip ? ST_PLAN : ST_CONV;
                end
            end
            ST_CONV: begin
                if (div_quot == '0) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:  state_next = ST_BOUND;
            ST_BOUND: state_next = (n_calc == '0) ? ST_IDLE : ST_EMIT;
            ST_EMIT: begin
                if (emit_load && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item capture and digit extraction.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            mag_reg  <= in_mag;
            neg_reg  <= in_neg;
            w_reg    <= CNT_W'(in_width_sat);
            p_reg    <= CNT_W'(in_prec_sat);
            hasp_reg <= in_hasp;
            zp_reg   <= in_zp;
            lj_reg   <= in_lj;
            ndig_reg <= '0;
        end else if (state_reg == ST_CONV) begin
            dig_reg[ndig_reg] <= div_rem;
            ndig_reg          <= ndig_reg + DIG_IDX_W'(1);
            mag_reg           <= div_quot;
        end
    end

    // Layout registers and the character position counters.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PLAN) begin
            zeros_reg <= zeros_calc;
            pad_reg   <= pad_calc;
        end
        if (state_reg == ST_BOUND) begin
            a_reg    <= a_calc;
            b_reg    <= b_calc;
            c_reg    <= c_calc;
            d_reg    <= d_calc;
            n_reg    <= n_calc;
            idx_reg  <= '0;
            dptr_reg <= ndig_reg - DIG_IDX_W'(1);
        end else if (emit_load) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (emit_digit) begin
                dptr_reg <= dptr_reg - DIG_IDX_W'(1);
            end
        end
    end

    // Output register: in the emit state, loads a character whenever it is empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_ch_reg   <= emit_ch;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_ch_reg};
    assign m_tlast  = m_last_reg;

    // A 32-bit magnitude never needs more than ten digit slots.
    `SDFF_ASSERT(a_digit_count, aclk, aresetn, (state_reg == ST_CONV) |-> (ndig_reg < DIG_IDX_W'(NUM_DIGITS)), "digit store overrun")

    // Emission only runs over a non-empty field and stops at its end.
    `SDFF_ASSERT(a_emit_range, aclk, aresetn, (state_reg == ST_EMIT) |-> (n_reg != '0 && idx_reg < n_reg), "character position outside the field")

    // Every presented character is a space, a minus sign or a digit.
    `SDFF_ASSERT(a_char_legal, aclk, aresetn, m_tvalid |-> (m_ch_reg == CH_SPACE || m_ch_reg == CH_MINUS || (m_ch_reg >= CH_ZERO && m_ch_reg <= CH_NINE)), "illegal output character")

    // A digit is only read when the store holds at least one digit.
    `SDFF_ASSERT(a_digit_read, aclk, aresetn, (emit_load && emit_digit) |-> (ndig_reg != '0), "digit read from an empty store")

    // Reset leaves no transaction on the output.
    `SDFF_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
